@@ design/scfe_pkg.sv @@
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types and constants for the servo command frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scfe_pkg;

  // Command opcodes
  localparam logic [2:0] OpParams   = 3'd0;
  localparam logic [2:0] OpSpeed    = 3'd1;
  localparam logic [2:0] OpPos7     = 3'd2;
  localparam logic [2:0] OpPos8     = 3'd3;
  localparam logic [2:0] OpAbsolute = 3'd4;
  localparam logic [2:0] OpNeutral  = 3'd5;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgStartByte = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDeviceId  = 2'd1;

  localparam logic [7:0] StartByteReset = 8'd128;
  localparam logic [6:0] DeviceIdReset  = 7'd1;

  // Range limits
  localparam logic [12:0] MaxRange   = 13'd15;
  localparam logic [12:0] MaxVal7    = 13'd127;
  localparam logic [12:0] MaxVal8    = 13'd255;
  localparam logic [12:0] MinAbs     = 13'd500;
  localparam logic [12:0] MaxAbs     = 13'd5500;
  localparam logic [7:0]  MaxChannel = 8'd15;

  // Frame byte positions, used as the back-end sequencer state
  localparam int unsigned ByteIdxW = 3;
  localparam logic [ByteIdxW-1:0] ByteStart = 3'd0;
  localparam logic [ByteIdxW-1:0] ByteId    = 3'd1;
  localparam logic [ByteIdxW-1:0] ByteOp    = 3'd2;
  localparam logic [ByteIdxW-1:0] ByteCh    = 3'd3;
  localparam logic [ByteIdxW-1:0] ByteBody0 = 3'd4;
  localparam logic [ByteIdxW-1:0] ByteBody1 = 3'd5;

  // Descriptor queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  channel;
    logic [12:0] value;
    logic        channel_on;
    logic        forward;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       rejected;
  } frame_byte_t;

  // Classified command, ready to serialize
  typedef struct packed {
    logic       ok;
    logic       two_body;
    logic [2:0] opcode;
    logic [3:0] channel;
    logic [6:0] body0;
    logic [6:0] body1;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

@@ design/scfe_front.sv @@
// ----------------------------------------------------------------------------
// scfe_front
// Accepts commands, range-checks them and builds frame descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_front (
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  scfe_pkg::cmd_t       in_data_i,
  input  scfe_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output scfe_pkg::desc_t      desc_o
);
  import scfe_pkg::*;

  logic       val_ok;
  logic       two_body;
  logic [6:0] body0;
  logic [6:0] body1;
  logic [12:0] val;

  assign val = in_data_i.value;

  always_comb begin
    val_ok   = 1'b0;
    two_body = 1'b0;
    body0    = val[6:0];
    body1    = val[6:0];
    unique case (in_data_i.opcode) inside
      OpParams: begin
        val_ok = (val <= MaxRange);
        body0  = {in_data_i.channel_on, ~in_data_i.forward, 1'b0, val[3:0]};
      end
      OpSpeed, OpPos7: begin
        val_ok = (val <= MaxVal7);
      end
      OpPos8: begin
        val_ok   = (val <= MaxVal8);
        two_body = 1'b1;
        body0    = {6'd0, val[7]};
      end
      OpAbsolute, OpNeutral: begin
        val_ok   = (val >= MinAbs) && (val <= MaxAbs);
        two_body = 1'b1;
        body0    = {1'b0, val[12:7]};
      end
      default: begin
        val_ok = 1'b0;
      end
    endcase
  end

  assign desc_o.ok       = val_ok && (in_data_i.channel <= MaxChannel);
  assign desc_o.two_body = two_body;
  assign desc_o.opcode   = in_data_i.opcode;
  assign desc_o.channel  = in_data_i.channel[3:0];
  assign desc_o.body0    = body0;
  assign desc_o.body1    = body1;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

`default_nettype wire

@@ design/scfe_queue.sv @@
// ----------------------------------------------------------------------------
// scfe_queue
// Short descriptor FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  scfe_pkg::desc_t      desc_i,
  input  wire                  pop_i,
  output scfe_pkg::desc_t      desc_o,
  output scfe_pkg::q_status_t  status_o
);
  import scfe_pkg::*;

  desc_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push did not raise count");

endmodule

`default_nettype wire

@@ design/scfe_back.sv @@
// ----------------------------------------------------------------------------
// scfe_back
// Walks the head descriptor byte by byte into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  [7:0]              start_byte_i,
  input  wire  [6:0]              device_id_i,
  input  scfe_pkg::desc_t         desc_i,
  input  scfe_pkg::q_status_t     q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output scfe_pkg::frame_byte_t   out_data_o
);
  import scfe_pkg::*;

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  frame_byte_t         out_q;
  frame_byte_t         nxt;
  logic                load;

  assign load = q_status_i.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    nxt = '{tx_byte: 8'd0, last: 1'b1, rejected: 1'b1};
    if (desc_i.ok) begin
      nxt.rejected = 1'b0;
      nxt.last     = 1'b0;
      unique case (idx_q)
        ByteStart: nxt.tx_byte = start_byte_i;
        ByteId:    nxt.tx_byte = {1'b0, device_id_i};
        ByteOp:    nxt.tx_byte = {5'd0, desc_i.opcode};
        ByteCh:    nxt.tx_byte = {4'd0, desc_i.channel};
        ByteBody0: begin
          nxt.tx_byte = {1'b0, desc_i.body0};
          nxt.last    = !desc_i.two_body;
        end
        ByteBody1: begin
          nxt.tx_byte = {1'b0, desc_i.body1};
          nxt.last    = 1'b1;
        end
        default: begin
          nxt.tx_byte = 8'd0;
          nxt.last    = 1'b1;
        end
      endcase
    end
  end

  assign pop_o = load && nxt.last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = nxt.last ? ByteStart : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= ByteStart;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rejected) |-> (out_q.last && out_q.tx_byte == 8'd0))
    else $error("reject result not a single zero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= ByteBody1)
    else $error("byte index out of frame");

  // a frame in progress keeps its descriptor at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != ByteStart) |-> q_status_i.valid)
    else $error("descriptor lost mid-frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !nxt.last) |=> (idx_q == $past(idx_q) + 1'b1))
    else $error("byte index did not advance");

endmodule

`default_nettype wire

@@ design/servo_command_frame_encoder_top.sv @@
// ----------------------------------------------------------------------------
// servo_command_frame_encoder_top
// Servo command to serial frame encoder.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_stall    cmd_t (opcode, channel, value, flags)
//   out       output     out_valid/out_stall  frame_byte_t (tx_byte, last, rejected)
//   cfg       input      cfg_we               cfg_idx, cfg_wdata
//
// One frame byte per cycle while out_stall is low; a command gives 5 or 6 bytes, a rejected one 1.
// The byte sequencer sets the frame length; a two-entry descriptor queue lets the
// input side take the next commands while a frame is still going out.
// A command is first written to the descriptor queue; its first byte then goes out through the output register.
// Reset: start byte 128, device id 1, queue and output empty.
// Output stall holds the output register; input stalls only when the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_command_frame_encoder_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  scfe_pkg::cmd_t                     in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output scfe_pkg::frame_byte_t              out_data_o,
  input  wire                                cfg_we_i,
  input  wire  [scfe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [7:0]                         cfg_wdata_i
);
  import scfe_pkg::*;

  logic [7:0] start_byte_q;
  logic [6:0] device_id_q;
  logic       push;
  logic       pop;
  desc_t      desc_in;
  desc_t      desc_head;
  q_status_t  q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
      device_id_q  <= DeviceIdReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartByte: start_byte_q <= cfg_wdata_i;
        CfgDeviceId:  device_id_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  scfe_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .desc_o     (desc_in)
  );

  scfe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (desc_in),
    .pop_i    (pop),
    .desc_o   (desc_head),
    .status_o (q_status)
  );

  scfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_byte_q),
    .device_id_i  (device_id_q),
    .desc_i       (desc_head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
